@@ hw/rtl/ssps_pkg.sv @@
// Shared constants and helpers for the sample set percentile summary block.
package ssps_pkg;

    localparam int MAX_SAMPLES  = 1024;
    localparam int SAMPLE_WIDTH = 32;
    localparam int ADDR_W       = $clog2(MAX_SAMPLES);
    localparam int CNT_W        = $clog2(MAX_SAMPLES + 1);
    localparam int CONF_W       = 10;
    localparam int PROD_W       = CONF_W + CNT_W;
    localparam int KIDX_W       = 3;
    localparam int NUM_TARGETS  = 5;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_CONFIDENCE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET     = 2'd1;

    localparam logic [CONF_W-1:0] PCT_FULL = 10'd1000;
    localparam logic [CONF_W-1:0] PCT_Q1   = 10'd250;
    localparam logic [CONF_W-1:0] PCT_MED  = 10'd500;
    localparam logic [CONF_W-1:0] PCT_Q3   = 10'd750;
    localparam logic [CONF_W-1:0] CONF_RESET = 10'd990;

    localparam logic [KIDX_W-1:0] TGT_LOW  = 3'd0;
    localparam logic [KIDX_W-1:0] TGT_Q1   = 3'd1;
    localparam logic [KIDX_W-1:0] TGT_MED  = 3'd2;
    localparam logic [KIDX_W-1:0] TGT_Q3   = 3'd3;
    localparam logic [KIDX_W-1:0] TGT_HIGH = 3'd4;

    typedef logic [SAMPLE_WIDTH-1:0] sample_t;

    function automatic logic [CONF_W-1:0] target_tenths(
        input logic [KIDX_W-1:0] k,
        input logic [CONF_W-1:0] conf
    );
        logic [CONF_W-1:0] c;
        logic [CONF_W-1:0] t;
        begin
            c = (conf > PCT_FULL) ? PCT_FULL : conf;
            case (k)
                TGT_LOW:  t = PCT_FULL - c;
                TGT_Q1:   t = PCT_Q1;
                TGT_MED:  t = PCT_MED;
                TGT_Q3:   t = PCT_Q3;
                default:  t = c;
            endcase
            return t;
        end
    endfunction

    function automatic sample_t sub_floor(input sample_t v, input sample_t off);
        begin
            return (v >= off) ? (v - off) : '0;
        end
    endfunction

endpackage

@@ hw/rtl/sample_set_percentile_summary.sv @@
// Top level: sample set loader, in-memory sort and percentile scan.
//
//  channel | signals                          | direction
//  in      | in_valid in_stall sample last    | samples into block
//  out     | out_valid out_stall *_value ...  | one summary per set
//  cfg     | cfg_valid cfg_ready cfg_index    | register writes
//
// Samples load at one per cycle into a 1024x32 RAM while in_stall is low.
// After last: insertion sort in the RAM, shifting larger entries up one place per
// compare until the element lands (n^2 worst case), then a scan that reads each
// element and checks each distinct value run against the five targets.
// in_stall is high from last until the summary is put in the output register.
// A waiting summary does not block loading of the next set.
// Reset clears control state only; the RAM needs no clearing.
module sample_set_percentile_summary (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [31:0]                         sample,
    input  logic                                last,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [31:0]                         min_value,
    output logic [31:0]                         low_tail_value,
    output logic [31:0]                         q1_value,
    output logic [31:0]                         median_value,
    output logic [31:0]                         q3_value,
    output logic [31:0]                         high_tail_value,
    output logic [31:0]                         max_value,
    output logic [10:0]                         distinct_count,
    output logic [10:0]                         sample_count,
    output logic                                overflowed,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ssps_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ssps_pkg::CFG_DATA_W-1:0]     cfg_data
);
    localparam int CW = ssps_pkg::CNT_W;
    localparam int AW = ssps_pkg::ADDR_W;

    localparam logic [2:0] S_LOAD = 3'd0;
    localparam logic [2:0] S_LDV  = 3'd1;
    localparam logic [2:0] S_CMP  = 3'd2;
    localparam logic [2:0] S_PLC  = 3'd3;
    localparam logic [2:0] S_SRD  = 3'd4;
    localparam logic [2:0] S_SDAT = 3'd5;
    localparam logic [2:0] S_CHK  = 3'd6;
    localparam logic [2:0] S_FIN  = 3'd7;

    logic [2:0]  state_reg, state_next;
    logic [CW-1:0] fill_reg, fill_next;
    logic        ovf_reg, ovf_next;
    logic        oval_reg, oval_next;
    logic [ssps_pkg::CONF_W-1:0] conf_reg, conf_next;
    ssps_pkg::sample_t offset_reg, offset_next;

    logic [CW-1:0] i_reg, i_next, j_reg, j_next, idx_reg, idx_next;
    logic [CW-1:0] gend_reg, gend_next, dist_reg, dist_next;
    logic [ssps_pkg::KIDX_W-1:0] k_reg, k_next;
    logic        final_reg, final_next;
    logic        fwd_reg, fwd_next;
    ssps_pkg::sample_t v_reg, v_next, prev_reg, prev_next, gval_reg, gval_next;
    ssps_pkg::sample_t min_reg, min_next;
    ssps_pkg::sample_t vals_reg [ssps_pkg::NUM_TARGETS];
    logic        vals_we;

    logic        we;
    logic [AW-1:0] waddr, raddr;
    ssps_pkg::sample_t wdata, rdata;

    logic [ssps_pkg::PROD_W-1:0] lhs, rhs;
    logic        hit;
    logic        in_acc, out_load;

    ssps_ram #(.WIDTH(ssps_pkg::SAMPLE_WIDTH), .DEPTH(ssps_pkg::MAX_SAMPLES)) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign in_stall  = (state_reg != S_LOAD);
    assign in_acc    = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign out_valid = oval_reg;
    assign out_load  = (state_reg == S_FIN) && (!oval_reg || !out_stall);

    assign lhs = ssps_pkg::PROD_W'(gend_reg) * ssps_pkg::PROD_W'(ssps_pkg::PCT_FULL);
    assign rhs = ssps_pkg::PROD_W'(ssps_pkg::target_tenths(k_reg, conf_reg))
               * ssps_pkg::PROD_W'(fill_reg);
    assign hit = (k_reg < ssps_pkg::KIDX_W'(ssps_pkg::NUM_TARGETS))
              && ((lhs >= rhs) || (gend_reg == fill_reg));

    always_comb
    begin
        state_next  = state_reg;
        fill_next   = fill_reg;
        ovf_next    = ovf_reg;
        oval_next   = oval_reg && out_stall;
        conf_next   = conf_reg;
        offset_next = offset_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        idx_next    = idx_reg;
        gend_next   = gend_reg;
        dist_next   = dist_reg;
        k_next      = k_reg;
        final_next  = final_reg;
        fwd_next    = fwd_reg;
        v_next      = v_reg;
        prev_next   = prev_reg;
        gval_next   = gval_reg;
        min_next    = min_reg;
        vals_we     = 1'b0;
        we          = 1'b0;
        waddr       = fill_reg[AW-1:0];
        wdata       = sample;
        raddr       = '0;

        if (cfg_valid)
        begin
            unique case (cfg_index)
                ssps_pkg::CFG_CONFIDENCE: conf_next = cfg_data[ssps_pkg::CONF_W-1:0];
                ssps_pkg::CFG_OFFSET:     offset_next = cfg_data;
                default: ;
            endcase
        end

        unique case (state_reg)
            S_LOAD:
            begin
                if (in_acc)
                begin
                    if (fill_reg < CW'(ssps_pkg::MAX_SAMPLES))
                    begin
                        we        = 1'b1;
                        fill_next = fill_reg + 1'b1;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (last)
                    begin
                        k_next = '0;
                        if (fill_next > CW'(1))
                        begin
                            i_next     = CW'(1);
                            raddr      = AW'(1);
                            // entry 1 is being written by this item
                            fwd_next   = (fill_reg == CW'(1));
                            v_next     = sample;
                            state_next = S_LDV;
                        end
                        else
                        begin
                            idx_next   = '0;
                            state_next = S_SRD;
                        end
                    end
                end
            end
            S_LDV:
            begin
                v_next     = fwd_reg ? v_reg : rdata;
                fwd_next   = 1'b0;
                j_next     = i_reg;
                raddr      = AW'(i_reg - 1'b1);
                state_next = S_CMP;
            end
            S_CMP, S_PLC:
            begin
                we = 1'b1;
                if (state_reg == S_CMP && rdata > v_reg)
                begin
                    waddr = j_reg[AW-1:0];
                    wdata = rdata;
                    if (j_reg == CW'(1))
                    begin
                        state_next = S_PLC;
                    end
                    else
                    begin
                        raddr  = AW'(j_reg - CW'(2));
                        j_next = j_reg - 1'b1;
                    end
                end
                else
                begin
                    waddr = (state_reg == S_PLC) ? '0 : j_reg[AW-1:0];
                    wdata = v_reg;
                    if (i_reg + 1'b1 < fill_reg)
                    begin
                        i_next     = i_reg + 1'b1;
                        raddr      = AW'(i_reg + 1'b1);
                        state_next = S_LDV;
                    end
                    else
                    begin
                        idx_next   = '0;
                        state_next = S_SRD;
                    end
                end
            end
            S_SRD:
            begin
                raddr      = idx_reg[AW-1:0];
                state_next = S_SDAT;
            end
            S_SDAT:
            begin
                if (idx_reg == '0)
                begin
                    prev_next = rdata;
                    min_next  = rdata;
                    dist_next = CW'(1);
                    if (fill_reg == CW'(1))
                    begin
                        gval_next  = rdata;
                        gend_next  = fill_reg;
                        final_next = 1'b1;
                        state_next = S_CHK;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_SRD;
                    end
                end
                else if (rdata != prev_reg)
                begin
                    gval_next  = prev_reg;
                    gend_next  = idx_reg;
                    prev_next  = rdata;
                    dist_next  = dist_reg + 1'b1;
                    final_next = 1'b0;
                    state_next = S_CHK;
                end
                else if (idx_reg == fill_reg - 1'b1)
                begin
                    gval_next  = rdata;
                    gend_next  = fill_reg;
                    final_next = 1'b1;
                    state_next = S_CHK;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_SRD;
                end
            end
            S_CHK:
            begin
                if (hit)
                begin
                    vals_we = 1'b1;
                    k_next  = k_reg + 1'b1;
                end
                else if (final_reg)
                begin
                    state_next = S_FIN;
                end
                else if (idx_reg == fill_reg - 1'b1)
                begin
                    gval_next  = prev_reg;
                    gend_next  = fill_reg;
                    final_next = 1'b1;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_SRD;
                end
            end
            S_FIN:
            begin
                if (out_load)
                begin
                    oval_next  = 1'b1;
                    fill_next  = '0;
                    ovf_next   = 1'b0;
                    state_next = S_LOAD;
                end
            end
            default: state_next = S_LOAD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_LOAD;
            fill_reg   <= '0;
            ovf_reg    <= 1'b0;
            oval_reg   <= 1'b0;
            conf_reg   <= ssps_pkg::CONF_RESET;
            offset_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            fill_reg   <= fill_next;
            ovf_reg    <= ovf_next;
            oval_reg   <= oval_next;
            conf_reg   <= conf_next;
            offset_reg <= offset_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg     <= i_next;
        j_reg     <= j_next;
        idx_reg   <= idx_next;
        gend_reg  <= gend_next;
        dist_reg  <= dist_next;
        k_reg     <= k_next;
        final_reg <= final_next;
        fwd_reg   <= fwd_next;
        v_reg     <= v_next;
        prev_reg  <= prev_next;
        gval_reg  <= gval_next;
        min_reg   <= min_next;
        if (vals_we)
        begin
            vals_reg[k_reg] <= gval_reg;
        end
        if (out_load)
        begin
            min_value       <= ssps_pkg::sub_floor(min_reg, offset_reg);
            low_tail_value  <= ssps_pkg::sub_floor(vals_reg[0], offset_reg);
            q1_value        <= ssps_pkg::sub_floor(vals_reg[1], offset_reg);
            median_value    <= ssps_pkg::sub_floor(vals_reg[2], offset_reg);
            q3_value        <= ssps_pkg::sub_floor(vals_reg[3], offset_reg);
            high_tail_value <= ssps_pkg::sub_floor(vals_reg[4], offset_reg);
            max_value       <= ssps_pkg::sub_floor(gval_reg, offset_reg);
            distinct_count  <= dist_reg;
            sample_count    <= fill_reg;
            overflowed      <= ovf_reg;
        end
    end
endmodule

@@ hw/rtl/ssps_ram.sv @@
// Generic simple dual-port RAM with registered read.
module ssps_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ hw/rtl/ssps_checker.sv @@
// Port-level checker for the percentile summary block, bound to the top level.
module ssps_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [31:0] min_value,
    input logic [31:0] q1_value,
    input logic [31:0] median_value,
    input logic [31:0] q3_value,
    input logic [31:0] max_value,
    input logic [10:0] distinct_count,
    input logic [10:0] sample_count
);
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(median_value))
        else $error("summary dropped or changed while stalled");

    a_counts: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> distinct_count != 11'd0 && distinct_count <= sample_count)
        else $error("distinct count inconsistent with sample count");

    a_order_low: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> min_value <= q1_value && q1_value <= median_value)
        else $error("summary values out of order (low side)");

    a_order_high: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> median_value <= q3_value && q3_value <= max_value)
        else $error("summary values out of order (high side)");
endmodule

bind sample_set_percentile_summary ssps_checker u_ssps_checker (.*);

@@ tb/tb_sample_set_percentile_summary.sv @@
// Testbench for the sample set percentile summary block: directed table, random sets, predictor.
module tb_sample_set_percentile_summary;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [31:0] vals [7];
        logic [10:0] distinct;
        logic [10:0] count;
        logic        ovf;
    } summary_t;

    typedef struct {
        logic [31:0] smp;
        logic        lst;
        bit          typed;
        summary_t    want;
    } row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [31:0] sample = '0;
    logic        last = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [31:0] min_value, low_tail_value, q1_value, median_value;
    logic [31:0] q3_value, high_tail_value, max_value;
    logic [10:0] distinct_count, sample_count;
    logic        overflowed;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [ssps_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [ssps_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    summary_t    summary_q [$];
    logic [31:0] kept [$];
    bit          kept_ovf;
    logic [9:0]  cur_conf;
    logic [31:0] cur_off;
    int          errors = 0;
    int          sets_done = 0;
    int          items_sent = 0;
    bit          quiet = 1'b0;
    bit          long_hold = 1'b0;
    row_t        rows [$];

    sample_set_percentile_summary dut (.*);

    always #5 clk = ~clk;

    initial
    begin
        #50_000_000;
        $display("CHECKS FAILED");
        $display("timeout: %0d summaries still due", summary_q.size());
        $finish;
    end

    function automatic logic [31:0] floor_sub(logic [31:0] v);
        return (v >= cur_off) ? v - cur_off : 32'd0;
    endfunction

    function automatic summary_t summarize();
        summary_t    r;
        logic [31:0] s [$];
        int          n, pos, stop, k;
        int          tg [5];
        int          conf;
        s = kept;
        s.sort();
        n = s.size();
        conf = (cur_conf > ssps_pkg::PCT_FULL) ? 1000 : int'(cur_conf);
        tg = '{1000 - conf, 250, 500, 750, conf};
        r.distinct = 0;
        for (int i = 0; i < n; i++)
            if (i == 0 || s[i] != s[i-1])
                r.distinct++;
        r.vals[0] = floor_sub(s[0]);
        r.vals[6] = floor_sub(s[n-1]);
        pos = 0;
        stop = 1;
        while (stop < n && s[stop] == s[0])
            stop++;
        for (k = 0; k < 5; k++)
        begin
            while (longint'(1000) * stop < longint'(tg[k]) * n && stop < n)
            begin
                pos = stop;
                stop = pos + 1;
                while (stop < n && s[stop] == s[pos])
                    stop++;
            end
            r.vals[k+1] = floor_sub(s[pos]);
        end
        r.count = 11'(n);
        r.ovf = kept_ovf;
        return r;
    endfunction

    // returns 1 when the item closes a set
    function automatic bit absorb(logic [31:0] v, logic l);
        if (kept.size() < ssps_pkg::MAX_SAMPLES)
            kept.push_back(v);
        else
            kept_ovf = 1'b1;
        return l;
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch set %0d %s: got %h want %h", sets_done, what, got, want);
        errors++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (summary_q.size() == 0)
            begin
                $display("unexpected summary at %0t", $realtime);
                errors++;
            end
            else
            begin
                summary_t w;
                w = summary_q.pop_front();
                if (min_value !== w.vals[0]) report("min", min_value, w.vals[0]);
                if (low_tail_value !== w.vals[1]) report("low_tail", low_tail_value, w.vals[1]);
                if (q1_value !== w.vals[2]) report("q1", q1_value, w.vals[2]);
                if (median_value !== w.vals[3]) report("median", median_value, w.vals[3]);
                if (q3_value !== w.vals[4]) report("q3", q3_value, w.vals[4]);
                if (high_tail_value !== w.vals[5])
                    report("high_tail", high_tail_value, w.vals[5]);
                if (max_value !== w.vals[6]) report("max", max_value, w.vals[6]);
                if (distinct_count !== w.distinct)
                    report("distinct", 32'(distinct_count), 32'(w.distinct));
                if (sample_count !== w.count)
                    report("count", 32'(sample_count), 32'(w.count));
                if (overflowed !== w.ovf) report("overflowed", 32'(overflowed), 32'(w.ovf));
                sets_done++;
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (quiet || r < 60) return 0;
        if (r < 90) return $urandom_range(3, 1);
        if (r < 98) return $urandom_range(20, 4);
        return $urandom_range(200, 30);
    endfunction

    initial
    begin
        int n;
        @(posedge rst_n);
        forever
        begin
            if (long_hold)
            begin
                out_stall <= 1'b1;
                repeat (3000) @(posedge clk);
                long_hold = 1'b0;
            end
            n = pick_gap();
            out_stall <= (n != 0);
            repeat (n == 0 ? $urandom_range(6, 1) : n) @(posedge clk);
        end
    end

    task automatic send(logic [31:0] v, logic l, bit typed, summary_t want);
        int g;
        in_valid <= 1'b1;
        sample <= v;
        last <= l;
        do @(posedge clk); while (in_stall);
        items_sent++;
        if (absorb(v, l))
        begin
            summary_q.push_back(typed ? want : summarize());
            kept.delete();
            kept_ovf = 1'b0;
        end
        g = pick_gap();
        if (g != 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (summary_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(logic [ssps_pkg::CFG_IDX_W-1:0] idx, logic [31:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        do @(posedge clk); while (!cfg_ready);
        if (idx == ssps_pkg::CFG_CONFIDENCE)
            cur_conf = d[9:0];
        else if (idx == ssps_pkg::CFG_OFFSET)
            cur_off = d;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic summary_t flat(logic [31:0] v, int cnt);
        summary_t r;
        foreach (r.vals[i]) r.vals[i] = v;
        r.distinct = 11'd1;
        r.count = 11'(cnt);
        r.ovf = 1'b0;
        return r;
    endfunction

    function automatic void add_row(logic [31:0] v, logic l, bit t, summary_t w);
        row_t r;
        r.smp = v;
        r.lst = l;
        r.typed = t;
        r.want = w;
        rows.push_back(r);
    endfunction

    function automatic logic [31:0] rand_value(int mode);
        case (mode)
            0: return $urandom();
            1: return $urandom_range(7);
            2: return $urandom_range(1) ? 32'hFFFF_FFFF - $urandom_range(3) : $urandom_range(3);
            default: return $urandom_range(300);
        endcase
    endfunction

    task automatic random_sets(int items);
        int sent, n, mode, r;
        sent = 0;
        while (sent < items)
        begin
            r = $urandom_range(99);
            n = (r < 85) ? $urandom_range(12, 1) : $urandom_range(60, 13);
            mode = $urandom_range(3);
            for (int i = 0; i < n; i++)
                send(rand_value(mode), i == n - 1, 1'b0, flat(32'd0, 0));
            sent += n;
        end
    endtask

    initial
    begin
        summary_t none;
        logic [9:0]  confs [8];
        logic [31:0] offs [8];
        none = flat(32'd0, 0);
        cur_conf = ssps_pkg::CONF_RESET;
        cur_off = 0;
        kept_ovf = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        add_row(32'h0, 1'b1, 1'b1, flat(32'h0, 1));
        add_row(32'hFFFF_FFFF, 1'b1, 1'b1, flat(32'hFFFF_FFFF, 1));
        add_row(32'd5, 1'b0, 1'b0, none);
        add_row(32'd5, 1'b0, 1'b0, none);
        add_row(32'd5, 1'b1, 1'b1, flat(32'd5, 3));
        for (int i = 0; i < 10; i++)
            add_row(32'((i * 7) % 10 + 1), i == 9, 1'b0, none);
        add_row(32'd3, 1'b0, 1'b0, none);
        add_row(32'd1, 1'b0, 1'b0, none);
        add_row(32'd3, 1'b0, 1'b0, none);
        add_row(32'hFFFF_FFFF, 1'b0, 1'b0, none);
        add_row(32'd1, 1'b1, 1'b0, none);
        foreach (rows[i])
            send(rows[i].smp, rows[i].lst, rows[i].typed, rows[i].want);
        settle();

        confs = '{10'd750, 10'd1000, 10'd1023, 10'd0, 10'd990, 10'd500, 10'd875, 10'd990};
        offs = '{32'd0, 32'hFFFF_FFFF, 32'd5, 32'd100, 32'h8000_0000, 32'd2, 32'd0, 32'd0};
        for (int ph = 0; ph < 8; ph++)
        begin
            if (ph == 6)
            begin
                confs[ph] = 10'($urandom_range(1000, 750));
                offs[ph] = $urandom_range(50);
            end
            write_reg(ssps_pkg::CFG_CONFIDENCE, 32'(confs[ph]));
            write_reg(ssps_pkg::CFG_OFFSET, offs[ph]);
            if (ph == 3)
            begin
                write_reg(2'd2, $urandom());
                write_reg(2'd3, $urandom());
            end
            quiet = (ph == 4);
            if (ph == 2)
                long_hold = 1'b1;
            if (ph == 5)
            begin
                // fill past capacity; the marked sample itself is dropped
                for (int i = 0; i < ssps_pkg::MAX_SAMPLES + 2; i++)
                    send(i * 3 + $urandom_range(2), i == ssps_pkg::MAX_SAMPLES + 1, 1'b0,
                         none);
            end
            random_sets(ph == 5 ? 30 : 80);
            settle();
        end
        quiet = 1'b0;

        $display("%0d items in %0d sets checked over 9 register settings", items_sent,
                 sets_done);
        $display("covered duplicates, extremes, offset floor, out-of-range confidence, overflow");
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
